// ===== hw/rtl/refcounted_id_pool_assert.svh =====
// Assertion macros for the reference-counted id pool.
// Included by the top level; depends on nothing else.
`ifndef REFCOUNTED_ID_POOL_ASSERT_SVH
`define REFCOUNTED_ID_POOL_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define RIP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold at the clock edge after the antecedent
`define RIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rip_pkg.sv =====
// Shared types and constants of the reference-counted id pool.
// No dependencies; imported by refcounted_id_pool.
package rip_pkg;

    // Field and register widths fixed by the interface
    localparam int FUNC_W   = 3;
    localparam int EID_IN_W = 8;
    localparam int CID_IN_W = 4;
    localparam int VALUE_W  = 32;
    localparam int CNT_O_W  = 16;
    localparam int ECNT_W   = 9;
    localparam int KIND_W   = 5;
    localparam int CFG_D_W  = 9;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC      = 3'd0,
        FN_ADD_REF    = 3'd1,
        FN_RELEASE    = 3'd2,
        FN_INSERT     = 3'd3,
        FN_REMOVE     = 3'd4,
        FN_READ_COUNT = 3'd5,
        FN_READ_SLOT  = 3'd6
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_status;

    // Configuration register indexes
    typedef enum logic {
        CFG_ENTITY_COUNT    = 1'b0,
        CFG_COMPONENT_KINDS = 1'b1
    } t_cfg_reg;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

endpackage

// ===== hw/rtl/refcounted_id_pool.sv =====
// Reference-counted id pool: free stack, count and component memories.
// Depends on rip_pkg and refcounted_id_pool_assert.svh.
//
// Hands out entity ids from a LIFO free stack, keeps a reference count
// per id and a table of component slots per id. For each transaction
// the accept edge registers the reads of the count, slot and stack
// memories (synchronous read), and the edge that leaves the update state does the
// update and write-back and loads the result register. A new transaction
// is taken on the cycle after that at the earliest; none is taken while
// one is in progress. A result that is not taken holds the block in its
// update cycle until the output register frees up. After reset and after
// every write of entity_count the block runs a clearing pass over the count
// and component memories, one entry per cycle (ids rounded up to a power of
// two times slots per id rounded up to a power of two, 4096 entries with
// the defaults), and takes no transaction meanwhile; configuration writes are
// taken at any time. The free stack needs no clearing: entries below the
// lowest stack depth reached since the last reinitialisation read as their
// own index.
`include "refcounted_id_pool_assert.svh"

module refcounted_id_pool
    import rip_pkg::*;
#(
    parameter int MAX_ENTITIES   = 256,
    parameter int MAX_COMPONENTS = 16,
    parameter int COUNT_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CFG_D_W-1:0]  i_cfg_data,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [EID_IN_W-1:0] i_entity_id,
    input  logic [CID_IN_W-1:0] i_component_id,
    input  logic [VALUE_W-1:0]  i_component_value,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [EID_IN_W-1:0] o_result_id,
    output logic [CNT_O_W-1:0]  o_ref_count,
    output logic [VALUE_W-1:0]  o_slot_value,
    output logic                o_recycled
);

    // Effective sizes: ids and slot indexes cannot exceed the field widths
    localparam int ENT_N   = (MAX_ENTITIES > 256) ? 256 : MAX_ENTITIES;
    localparam int CMP_N   = (MAX_COMPONENTS > 16) ? 16 : MAX_COMPONENTS;
    localparam int EID_W   = $clog2(ENT_N);
    localparam int CID_W   = (CMP_N > 1) ? $clog2(CMP_N) : 1;
    localparam int SLOT_AW = EID_W + CID_W;
    localparam int ENT_D   = 2 ** EID_W;
    localparam int SLOT_D  = 2 ** SLOT_AW;

    localparam logic [ECNT_W-1:0]     ENT_N_V  = ECNT_W'(ENT_N);
    localparam logic [KIND_W-1:0]     CMP_N_V  = KIND_W'(CMP_N);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [SLOT_AW-1:0]    CLR_LAST = '1;

    // Memories
    logic [COUNT_BITS-1:0] m_count [ENT_D];
    logic [VALUE_W-1:0]    m_slot  [SLOT_D];
    logic [EID_W-1:0]      m_stack [ENT_D];

    // Control state
    t_state               r_state;
    logic [SLOT_AW-1:0]   r_clr_addr;
    logic [ECNT_W-1:0]    r_entity_count;
    logic [KIND_W-1:0]    r_comp_kinds;
    logic [ECNT_W-1:0]    r_depth;
    logic [ECNT_W-1:0]    r_min;
    logic                 r_out_vld;

    // Captured transaction and memory read data
    logic [FUNC_W-1:0]     r_func;
    logic [EID_IN_W-1:0]   r_eid;
    logic [CID_IN_W-1:0]   r_cid;
    logic [VALUE_W-1:0]    r_val;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [VALUE_W-1:0]    r_slot_rd;
    logic [EID_W-1:0]      r_stack_rd;

    // Result register
    t_status             r_status;
    logic [EID_IN_W-1:0] r_rid;
    logic [CNT_O_W-1:0]  r_cnt;
    logic [VALUE_W-1:0]  r_slot;
    logic                r_rec;

    // Next values from the update cycle
    t_status               n_status;
    logic [EID_IN_W-1:0]   n_rid;
    logic [COUNT_BITS-1:0] n_cnt_full;
    logic [CNT_O_W-1:0]    n_cnt;
    logic [VALUE_W-1:0]    n_slot;
    logic                  n_rec;
    logic [ECNT_W-1:0]     n_depth;
    logic [ECNT_W-1:0]     n_min;

    // Update-cycle memory write requests
    logic                  x_cnt_we;
    logic [EID_W-1:0]      x_cnt_waddr;
    logic [COUNT_BITS-1:0] x_cnt_wdata;
    logic                  x_slot_we;
    logic [VALUE_W-1:0]    x_slot_wdata;
    logic                  x_stk_we;

    // Memory write ports after the clearing mux
    logic                  w_cnt_we;
    logic [EID_W-1:0]      w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic                  w_slot_we;
    logic [SLOT_AW-1:0]    w_slot_waddr;
    logic [VALUE_W-1:0]    w_slot_wdata;

    logic                  w_accept;
    logic                  w_cfg;
    logic                  w_fire;
    logic [ECNT_W-1:0]     w_top;
    logic [EID_W-1:0]      w_pop_id;
    logic                  w_eid_ok;
    logic                  w_cid_ok;
    logic [SLOT_AW-1:0]    w_slot_addr;
    logic [31:0]           w_cnt32;
    logic [ECNT_W-1:0]     w_ec;
    logic [KIND_W-1:0]     w_ck;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign w_cfg       = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_fire      = (r_state == S_EXEC) && (!r_out_vld || i_out_ready);

    // Register write clamping
    always_comb begin
        w_ec = i_cfg_data[ECNT_W-1:0];
        if (w_ec == '0) begin
            w_ec = ECNT_W'(1);
        end else if (w_ec > ENT_N_V) begin
            w_ec = ENT_N_V;
        end
        w_ck = i_cfg_data[KIND_W-1:0];
        if (w_ck == '0) begin
            w_ck = KIND_W'(1);
        end else if (w_ck > CMP_N_V) begin
            w_ck = CMP_N_V;
        end
    end

    // Stack top; entries below the low-water mark read as their own index
    assign w_top    = r_depth - ECNT_W'(1);
    assign w_pop_id = (w_top < r_min) ? w_top[EID_W-1:0] : r_stack_rd;
    assign w_eid_ok = ({1'b0, r_eid} < r_entity_count);
    assign w_cid_ok = ({1'b0, r_cid} < r_comp_kinds);
    assign w_slot_addr = {r_eid[EID_W-1:0], r_cid[CID_W-1:0]};

    // Update cycle: decide the result and the write-back
    always_comb begin
        n_status     = STAT_OK;
        n_rid        = r_eid;
        n_cnt_full   = r_cnt_rd;
        n_slot       = '0;
        n_rec        = 1'b0;
        n_depth      = r_depth;
        n_min        = r_min;
        x_cnt_we     = 1'b0;
        x_cnt_waddr  = r_eid[EID_W-1:0];
        x_cnt_wdata  = r_cnt_rd;
        x_slot_we    = 1'b0;
        x_slot_wdata = '0;
        x_stk_we     = 1'b0;
        unique case (r_func)
            FN_ALLOC: begin
                if (r_depth == '0) begin
                    n_status   = STAT_EMPTY;
                    n_rid      = '0;
                    n_cnt_full = '0;
                end else begin
                    n_depth     = w_top;
                    n_min       = (w_top < r_min) ? w_top : r_min;
                    n_rid       = EID_IN_W'(w_pop_id);
                    n_cnt_full  = CNT_ONE;
                    x_cnt_we    = 1'b1;
                    x_cnt_waddr = w_pop_id;
                    x_cnt_wdata = CNT_ONE;
                end
            end
            default: begin
                if (!w_eid_ok) begin
                    n_status   = STAT_INVALID;
                    n_cnt_full = '0;
                end else begin
                    unique case (r_func)
                        FN_ADD_REF: begin
                            if (r_cnt_rd == '0 || r_cnt_rd == CNT_MAX) begin
                                n_status = STAT_REFUSED;
                            end else begin
                                n_cnt_full  = r_cnt_rd + CNT_ONE;
                                x_cnt_we    = 1'b1;
                                x_cnt_wdata = n_cnt_full;
                            end
                        end
                        FN_RELEASE: begin
                            if (r_cnt_rd == '0) begin
                                n_status = STAT_REFUSED;
                            end else begin
                                n_cnt_full  = r_cnt_rd - CNT_ONE;
                                x_cnt_we    = 1'b1;
                                x_cnt_wdata = n_cnt_full;
                                // last reference gone: id goes back on the stack unless it is full
                                if (r_cnt_rd == CNT_ONE) begin
                                    n_rec = 1'b1;
                                    if (r_depth < ENT_N_V) begin
                                        x_stk_we = 1'b1;
                                        n_depth  = r_depth + ECNT_W'(1);
                                    end
                                end
                            end
                        end
                        FN_READ_COUNT: begin
                            n_status = STAT_OK;
                        end
                        FN_INSERT, FN_REMOVE, FN_READ_SLOT: begin
                            if (!w_cid_ok) begin
                                n_status = STAT_INVALID;
                            end else if (r_func == FN_INSERT) begin
                                if (r_val == '0 || r_slot_rd != '0) begin
                                    n_status = STAT_REFUSED;
                                    n_slot   = r_slot_rd;
                                end else begin
                                    n_slot       = r_val;
                                    x_slot_we    = 1'b1;
                                    x_slot_wdata = r_val;
                                end
                            end else if (r_func == FN_REMOVE) begin
                                if (r_slot_rd == '0) begin
                                    n_status = STAT_REFUSED;
                                end else begin
                                    n_slot    = r_slot_rd;
                                    x_slot_we = 1'b1;
                                end
                            end else begin
                                n_slot = r_slot_rd;
                            end
                        end
                        default: begin
                            n_status   = STAT_INVALID;
                            n_cnt_full = '0;
                        end
                    endcase
                end
            end
        endcase
    end

    // Count output is the low bits of the stored count
    assign w_cnt32 = 32'(n_cnt_full);
    assign n_cnt   = w_cnt32[CNT_O_W-1:0];

    // Write ports: the clearing pass owns them while it runs
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_cnt_we     = 1'b1;
            w_cnt_waddr  = r_clr_addr[SLOT_AW-1:CID_W];
            w_cnt_wdata  = '0;
            w_slot_we    = 1'b1;
            w_slot_waddr = r_clr_addr;
            w_slot_wdata = '0;
        end else begin
            w_cnt_we     = w_fire & x_cnt_we;
            w_cnt_waddr  = x_cnt_waddr;
            w_cnt_wdata  = x_cnt_wdata;
            w_slot_we    = w_fire & x_slot_we;
            w_slot_waddr = w_slot_addr;
            w_slot_wdata = x_slot_wdata;
        end
    end

    // Count memory
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            m_count[w_cnt_waddr] <= w_cnt_wdata;
        end
        if (w_accept) begin
            r_cnt_rd <= m_count[i_entity_id[EID_W-1:0]];
        end
    end

    // Component slot memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            m_slot[w_slot_waddr] <= w_slot_wdata;
        end
        if (w_accept) begin
            r_slot_rd <= m_slot[{i_entity_id[EID_W-1:0], i_component_id[CID_W-1:0]}];
        end
    end

    // Free stack memory: push at the depth, read the top
    always_ff @(posedge i_clk) begin
        if (w_fire && x_stk_we) begin
            m_stack[r_depth[EID_W-1:0]] <= r_eid[EID_W-1:0];
        end
        if (w_accept) begin
            r_stack_rd <= m_stack[w_top[EID_W-1:0]];
        end
    end

    // Sequencer, stack pointer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_entity_count <= ENT_N_V;
            r_comp_kinds   <= CMP_N_V;
            r_depth        <= ENT_N_V;
            r_min          <= ENT_N_V;
            r_out_vld      <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SLOT_AW'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_state   <= S_IDLE;
                        r_depth   <= n_depth;
                        r_min     <= n_min;
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // entity_count write reinitialises the pool
            if (w_cfg && i_cfg_index == CFG_ENTITY_COUNT) begin
                r_entity_count <= w_ec;
                r_depth        <= w_ec;
                r_min          <= w_ec;
                r_clr_addr     <= '0;
                r_state        <= S_CLEAR;
            end
            if (w_cfg && i_cfg_index == CFG_COMPONENT_KINDS) begin
                r_comp_kinds <= w_ck;
            end
        end
    end

    // Transaction capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_eid  <= i_entity_id;
            r_cid  <= i_component_id;
            r_val  <= i_component_value;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_cnt    <= n_cnt;
            r_slot   <= n_slot;
            r_rec    <= n_rec;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_status;
    assign o_result_id  = r_rid;
    assign o_ref_count  = r_cnt;
    assign o_slot_value = r_slot;
    assign o_recycled   = r_rec;

    // Checks
    `RIP_ASSERT_ALWAYS(a_depth_bound, i_clk, i_rst_n,
        r_depth <= r_entity_count, "free stack deeper than entity count")
    `RIP_ASSERT_ALWAYS(a_low_mark, i_clk, i_rst_n,
        r_min <= r_depth, "stack low-water mark above depth")
    `RIP_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_fire && !i_cfg_valid,
        o_out_valid && r_state == S_IDLE, "update cycle did not load a result")

endmodule
